/* rtl/core/waypoint_sequencer_macros.svh */
// ----------------------------------------------------------------------------
// waypoint sequencer assertion macros
// concurrent assertion shorthands shared by the waypoint sequencer rtl
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_SEQUENCER_MACROS_SVH
`define WAYPOINT_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF
// condition must never hold outside reset
`define WPS_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("assertion failed: forbidden condition seen");
// same-cycle implication outside reset
`define WPS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");
`else
`define WPS_ASSERT_NEVER(lbl, clk, rstn, cond)
`define WPS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/core/wps_pkg.sv */
// ----------------------------------------------------------------------------
// wps_pkg
// shared types, widths and codes of the waypoint sequencer
// ----------------------------------------------------------------------------
package wps_pkg;

    // table size
    localparam int MAX_WAYPOINTS = 64;
    localparam int IDX_W         = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W         = $clog2(MAX_WAYPOINTS + 1);

    // field widths
    localparam int ENTRY_W  = 6;
    localparam int NUM_W    = 7;
    localparam int COORD_W  = 24;
    localparam int TIME_W   = 32;
    localparam int RAD_W    = 23;
    localparam int SPEED_W  = 16;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int DIST_W   = SQ_W + 1;
    localparam int R2_W     = 2 * RAD_W;

    // stream and register port widths
    localparam int IN_TDATA_W  = 112;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_TUSER_W = 2;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int REG_SEL_W   = 3;

    // request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_POSE = 1'b1;

    // register indexes
    localparam logic [REG_SEL_W-1:0] REG_NUM_WAYPOINTS  = 3'd0;
    localparam logic [REG_SEL_W-1:0] REG_XY_RADIUS      = 3'd1;
    localparam logic [REG_SEL_W-1:0] REG_Z_BOUND        = 3'd2;
    localparam logic [REG_SEL_W-1:0] REG_WAIT_TIME      = 3'd3;
    localparam logic [REG_SEL_W-1:0] REG_PUBLISH_PERIOD = 3'd4;
    localparam logic [REG_SEL_W-1:0] REG_SPEED          = 3'd5;
    localparam logic [REG_SEL_W-1:0] REG_SEND_SPEED     = 3'd6;
    localparam logic [REG_SEL_W-1:0] REG_SEND_BOUNDARY  = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } wp_t;

    localparam int WP_W = $bits(wp_t);

    typedef struct packed {
        logic               req_type;
        logic [ENTRY_W-1:0] entry_index;
        wp_t                pos;
        logic [TIME_W-1:0]  timestamp;
    } item_t;

    typedef struct packed {
        logic [NUM_W-1:0]   num_waypoints;
        logic [RAD_W-1:0]   xy_radius;
        logic [RAD_W-1:0]   z_bound;
        logic [TIME_W-1:0]  wait_time;
        logic [TIME_W-1:0]  publish_period;
        logic [SPEED_W-1:0] speed;
        logic               send_speed;
        logic               send_boundary;
    } cfg_t;

    // squared horizontal distances and vertical check against one waypoint
    typedef struct packed {
        logic [SQ_W-1:0] sq_x;
        logic [SQ_W-1:0] sq_y;
        logic            z_ok;
    } range_t;

    // what the commit stage retires at the current edge
    typedef struct packed {
        logic             load_we;
        logic [IDX_W-1:0] load_idx;
        wp_t              load_wp;
        logic             advance;
    } commit_t;

    typedef struct packed {
        logic                      target_valid;
        logic [ENTRY_W-1:0]        target_index;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_z;
        logic                      is_waiting;
        logic                      speed_valid;
        logic [SPEED_W-1:0]        speed_value;
        logic                      boundary_refresh;
    } result_t;

endpackage

/* rtl/core/waypoint_sequencer.sv */
// ----------------------------------------------------------------------------
// waypoint_sequencer: waypoint follower with dwell time, stream in, stream out
// path: a result passes the input, distance and output registers before it is on m_tvalid
// throughput: one item per cycle while the result stream does not back up, set by the commit stage loop
// reset: synchronous; clears pipeline, index, dwell and refresh state, registers to defaults
// ----------------------------------------------------------------------------
`include "waypoint_sequencer_macros.svh"

module waypoint_sequencer (
    input  logic                             aclk,
    input  logic                             aresetn,

    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // entry_index[5:0], pos_x[29:6], pos_y[53:30], pos_z[77:54], timestamp[109:78]
    input  logic [wps_pkg::IN_TDATA_W-1:0]   s_tdata,
    // req_type[0]
    input  logic [wps_pkg::IN_TUSER_W-1:0]   s_tuser,

    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // target_index[5:0], target_x[29:6], target_y[53:30], target_z[77:54],
    // is_waiting[78], speed_value[94:79], boundary_refresh[95]
    output logic [wps_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // target_valid[0], speed_valid[1]
    output logic [wps_pkg::OUT_TUSER_W-1:0]  m_tuser,

    // register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wps_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [wps_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [wps_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import wps_pkg::*;

    localparam cfg_t CFG_RESET = '{
        num_waypoints:  NUM_W'(0),
        xy_radius:      RAD_W'(50),
        z_bound:        RAD_W'(500),
        wait_time:      TIME_W'(0),
        publish_period: TIME_W'(200),
        speed:          SPEED_W'(1000),
        send_speed:     1'b1,
        send_boundary:  1'b1
    };

    // ------------------------------------------------------------------
    // register file
    // ------------------------------------------------------------------
    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 cfg_wr;
    logic [REG_SEL_W-1:0] reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            unique case (reg_sel)
                REG_NUM_WAYPOINTS:  cfg_next.num_waypoints  = pwdata[NUM_W-1:0];
                REG_XY_RADIUS:      cfg_next.xy_radius      = pwdata[RAD_W-1:0];
                REG_Z_BOUND:        cfg_next.z_bound        = pwdata[RAD_W-1:0];
                REG_WAIT_TIME:      cfg_next.wait_time      = pwdata[TIME_W-1:0];
                REG_PUBLISH_PERIOD: cfg_next.publish_period = pwdata[TIME_W-1:0];
                REG_SPEED:          cfg_next.speed          = pwdata[SPEED_W-1:0];
                REG_SEND_SPEED:     cfg_next.send_speed     = pwdata[0];
                REG_SEND_BOUNDARY:  cfg_next.send_boundary  = pwdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read back, zero-extended to the bus width
    always_comb begin
        unique case (reg_sel)
            REG_NUM_WAYPOINTS:  prdata = APB_DATA_W'(cfg_reg.num_waypoints);
            REG_XY_RADIUS:      prdata = APB_DATA_W'(cfg_reg.xy_radius);
            REG_Z_BOUND:        prdata = APB_DATA_W'(cfg_reg.z_bound);
            REG_WAIT_TIME:      prdata = APB_DATA_W'(cfg_reg.wait_time);
            REG_PUBLISH_PERIOD: prdata = APB_DATA_W'(cfg_reg.publish_period);
            REG_SPEED:          prdata = APB_DATA_W'(cfg_reg.speed);
            REG_SEND_SPEED:     prdata = APB_DATA_W'(cfg_reg.send_speed);
            REG_SEND_BOUNDARY:  prdata = APB_DATA_W'(cfg_reg.send_boundary);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline control
    //   a: input register, b: distance results, then commit into the
    //   output register; every stage moves when the one after it frees up
    // ------------------------------------------------------------------
    logic    a_valid_reg;
    logic    a_valid_next;
    item_t   a_item_reg;
    item_t   s_item;
    logic    b_valid_reg;
    logic    b_valid_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;

    logic    s_xfer;
    logic    a_move;
    logic    b_commit;
    logic    b_emit;
    logic    out_free;

    commit_t          commit;
    result_t          result;
    item_t            b_item;
    range_t           b_range;
    wp_t              cur_wp;
    wp_t              nxt_wp;
    wp_t              cur_fwd;
    wp_t              nxt_fwd;
    logic [IDX_W-1:0] cur_idx;

    // unpack the input transfer
    always_comb begin
        s_item.req_type    = s_tuser[0];
        s_item.entry_index = s_tdata[5:0];
        s_item.pos.x       = s_tdata[29:6];
        s_item.pos.y       = s_tdata[53:30];
        s_item.pos.z       = s_tdata[77:54];
        s_item.timestamp   = s_tdata[109:78];
    end

    assign out_free = !out_valid_reg || m_tready;
    assign a_move   = a_valid_reg && (!b_valid_reg || b_commit);
    assign s_tready = !a_valid_reg || a_move;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_xfer) begin
            a_valid_next = 1'b1;
        end else if (a_move) begin
            a_valid_next = 1'b0;
        end

        b_valid_next = b_valid_reg;
        if (a_move) begin
            b_valid_next = 1'b1;
        end else if (b_commit) begin
            b_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (b_commit && b_emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            a_item_reg <= s_item;
        end
        if (b_commit && b_emit) begin
            out_reg <= result;
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    wps_wp_cache u_cache (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (commit),
        .cur_idx (cur_idx),
        .cur_wp  (cur_wp),
        .nxt_wp  (nxt_wp),
        .cur_fwd (cur_fwd),
        .nxt_fwd (nxt_fwd)
    );

    // the item ahead commits on the same edge, so its advance picks the candidate
    wps_range u_range (
        .aclk    (aclk),
        .a_move  (a_move),
        .a_item  (a_item_reg),
        .cur_fwd (cur_fwd),
        .nxt_fwd (nxt_fwd),
        .sel_nxt (commit.advance),
        .z_bound (cfg_reg.z_bound),
        .b_item  (b_item),
        .b_range (b_range)
    );

    wps_track u_track (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .b_valid  (b_valid_reg),
        .b_item   (b_item),
        .b_range  (b_range),
        .cur_wp   (cur_wp),
        .nxt_wp   (nxt_wp),
        .out_free (out_free),
        .b_commit (b_commit),
        .b_emit   (b_emit),
        .commit   (commit),
        .result   (result),
        .cur_idx  (cur_idx)
    );

    // ------------------------------------------------------------------
    // result stream
    // ------------------------------------------------------------------
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.boundary_refresh, out_reg.speed_value, out_reg.is_waiting,
                       out_reg.target_z, out_reg.target_y, out_reg.target_x,
                       out_reg.target_index};
    assign m_tuser  = {out_reg.speed_valid, out_reg.target_valid};

    // input side only backs up when both stages hold an item
    `WPS_ASSERT_IMPL(a_stall_full, aclk, aresetn, !s_tready, a_valid_reg && b_valid_reg)

endmodule

/* rtl/core/wps_ram.sv */
// ----------------------------------------------------------------------------
// wps_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module wps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/wps_wp_cache.sv */
// ----------------------------------------------------------------------------
// wps_wp_cache
// waypoint table ram with cached current and next entries
// ----------------------------------------------------------------------------
`include "waypoint_sequencer_macros.svh"

module wps_wp_cache (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  wps_pkg::commit_t         commit,
    input  logic [wps_pkg::IDX_W-1:0] cur_idx,
    output wps_pkg::wp_t             cur_wp,
    output wps_pkg::wp_t             nxt_wp,
    output wps_pkg::wp_t             cur_fwd,
    output wps_pkg::wp_t             nxt_fwd
);
    import wps_pkg::*;

    wp_t              cur_reg;
    wp_t              cur_next;
    wp_t              nxt_reg;
    wp_t              nxt_next;
    logic             fill_pend_reg;
    logic             fill_pend_next;
    logic [IDX_W-1:0] nxt_idx;
    logic [IDX_W-1:0] rd_addr;
    logic [WP_W-1:0]  rd_data;
    logic             hit_cur;
    logic             hit_nxt;

    // prefetch two ahead so the ram read already holds the new next entry when an advance commits
    assign nxt_idx = IDX_W'(cur_idx + IDX_W'(1));
    assign rd_addr = IDX_W'(cur_idx + IDX_W'(2));

    wps_ram #(
        .WIDTH (WP_W),
        .DEPTH (MAX_WAYPOINTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (commit.load_we),
        .wr_addr (commit.load_idx),
        .wr_data (commit.load_wp),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign hit_cur = commit.load_we && (commit.load_idx == cur_idx);
    assign hit_nxt = commit.load_we && (commit.load_idx == nxt_idx);

    always_comb begin
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        fill_pend_next = commit.advance;
        if (hit_cur) begin
            cur_next = commit.load_wp;
        end else if (commit.advance) begin
            cur_next = nxt_reg;
        end
        // a load landing on the new next entry wins over the refill
        if (hit_nxt) begin
            nxt_next = commit.load_wp;
        end else if (fill_pend_reg) begin
            nxt_next = wp_t'(rd_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_pend_reg <= 1'b0;
        end else begin
            fill_pend_reg <= fill_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        nxt_reg <= nxt_next;
    end

    assign cur_wp  = cur_reg;
    assign nxt_wp  = nxt_reg;
    assign cur_fwd = hit_cur ? commit.load_wp : cur_reg;
    assign nxt_fwd = hit_nxt ? commit.load_wp : nxt_reg;

    // advances are at least two items apart, so a refill never overlaps one
    `WPS_ASSERT_NEVER(a_fill_overlap, aclk, aresetn, fill_pend_reg && commit.advance)

endmodule

/* rtl/core/wps_range.sv */
// ----------------------------------------------------------------------------
// wps_range
// distance stage: squared offsets against current and next waypoint
// ----------------------------------------------------------------------------
module wps_range (
    input  logic                      aclk,
    input  logic                      a_move,
    input  wps_pkg::item_t            a_item,
    input  wps_pkg::wp_t              cur_fwd,
    input  wps_pkg::wp_t              nxt_fwd,
    input  logic                      sel_nxt,
    input  logic [wps_pkg::RAD_W-1:0] z_bound,
    output wps_pkg::item_t            b_item,
    output wps_pkg::range_t           b_range
);
    import wps_pkg::*;

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[COORD_W] ? COORD_W'(-d) : COORD_W'(d);
    endfunction

    function automatic range_t measure(
        input wp_t              p,
        input wp_t              w,
        input logic [RAD_W-1:0] zb
    );
        range_t           r;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] az;
        ax     = abs_diff(p.x, w.x);
        ay     = abs_diff(p.y, w.y);
        az     = abs_diff(p.z, w.z);
        r.sq_x = SQ_W'(ax) * SQ_W'(ax);
        r.sq_y = SQ_W'(ay) * SQ_W'(ay);
        r.z_ok = az < COORD_W'(zb);
        return r;
    endfunction

    item_t  b_item_reg;
    range_t cand_reg [2];
    logic   sel_nxt_reg;

    // both candidates are measured; the commit of the item ahead picks one
    always_ff @(posedge aclk) begin
        if (a_move) begin
            b_item_reg  <= a_item;
            cand_reg[0] <= measure(a_item.pos, cur_fwd, z_bound);
            cand_reg[1] <= measure(a_item.pos, nxt_fwd, z_bound);
            sel_nxt_reg <= sel_nxt;
        end
    end

    assign b_item  = b_item_reg;
    assign b_range = sel_nxt_reg ? cand_reg[1] : cand_reg[0];

endmodule

/* rtl/core/wps_track.sv */
// ----------------------------------------------------------------------------
// wps_track
// commit stage: arrival, dwell, advance and refresh decisions
// ----------------------------------------------------------------------------
`include "waypoint_sequencer_macros.svh"

module wps_track (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  wps_pkg::cfg_t             cfg,
    input  logic                      b_valid,
    input  wps_pkg::item_t            b_item,
    input  wps_pkg::range_t           b_range,
    input  wps_pkg::wp_t              cur_wp,
    input  wps_pkg::wp_t              nxt_wp,
    input  logic                      out_free,
    output logic                      b_commit,
    output logic                      b_emit,
    output wps_pkg::commit_t          commit,
    output wps_pkg::result_t          result,
    output logic [wps_pkg::IDX_W-1:0] cur_idx
);
    import wps_pkg::*;

    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              wait_reg;
    logic              wait_next;
    logic [TIME_W-1:0] dwell_reg;
    logic [TIME_W-1:0] dwell_next;
    logic [TIME_W-1:0] last_reg;
    logic [TIME_W-1:0] last_next;
    logic [R2_W-1:0]   r2_reg;

    logic              is_pose;
    logic [CNT_W-1:0]  count;
    logic              has_wp;
    logic [DIST_W-1:0] dist_sq;
    logic              near;
    logic              arrive;
    logic              wait_mid;
    logic [TIME_W-1:0] dwell_mid;
    logic [TIME_W-1:0] elapsed;
    logic [CNT_W-1:0]  idx_inc;
    logic              advance;
    logic [TIME_W-1:0] since;
    logic              tgt_valid;
    wp_t               tgt;

    // squared radius, refreshed every cycle from the register
    always_ff @(posedge aclk) begin
        r2_reg <= R2_W'(cfg.xy_radius) * R2_W'(cfg.xy_radius);
    end

    always_comb begin
        is_pose   = b_item.req_type == REQ_POSE;
        count     = (CNT_W'(cfg.num_waypoints) > CNT_W'(MAX_WAYPOINTS))
                    ? CNT_W'(MAX_WAYPOINTS) : CNT_W'(cfg.num_waypoints);
        has_wp    = count != '0;
        dist_sq   = DIST_W'(b_range.sq_x) + DIST_W'(b_range.sq_y);
        near      = (dist_sq < DIST_W'(r2_reg)) && b_range.z_ok;
        // arrival
        arrive    = has_wp && !wait_reg && near;
        wait_mid  = wait_reg || arrive;
        dwell_mid = arrive ? b_item.timestamp : dwell_reg;
        // advance
        elapsed   = b_item.timestamp - dwell_mid;
        idx_inc   = CNT_W'(idx_reg) + CNT_W'(1);
        advance   = has_wp && wait_mid && (elapsed > cfg.wait_time) && (idx_inc < count);
        // refresh
        since     = b_item.timestamp - last_reg;
        b_emit    = b_valid && is_pose && (since > cfg.publish_period);
        b_commit  = b_valid && (!b_emit || out_free);
    end

    always_comb begin
        idx_next   = idx_reg;
        wait_next  = wait_reg;
        dwell_next = dwell_reg;
        last_next  = last_reg;
        if (b_commit && is_pose) begin
            idx_next   = advance ? IDX_W'(idx_inc) : idx_reg;
            wait_next  = wait_mid && !advance;
            dwell_next = dwell_mid;
            if (b_emit) begin
                last_next = b_item.timestamp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            wait_reg  <= 1'b0;
            dwell_reg <= '0;
            last_reg  <= '0;
        end else begin
            idx_reg   <= idx_next;
            wait_reg  <= wait_next;
            dwell_reg <= dwell_next;
            last_reg  <= last_next;
        end
    end

    always_comb begin
        commit.load_we  = b_commit && !is_pose;
        commit.load_idx = IDX_W'(b_item.entry_index);
        commit.load_wp  = b_item.pos;
        commit.advance  = b_commit && is_pose && advance;
    end

    // target after this item's steps
    always_comb begin
        tgt                     = advance ? nxt_wp : cur_wp;
        tgt_valid               = has_wp && !(wait_mid && !advance);
        result.target_valid     = tgt_valid;
        result.target_index     = tgt_valid ? ENTRY_W'(idx_next) : '0;
        result.target_x         = tgt_valid ? tgt.x : '0;
        result.target_y         = tgt_valid ? tgt.y : '0;
        result.target_z         = tgt_valid ? tgt.z : '0;
        result.is_waiting       = wait_mid && !advance;
        result.speed_valid      = cfg.send_speed;
        result.speed_value      = cfg.send_speed ? cfg.speed : '0;
        result.boundary_refresh = cfg.send_boundary;
    end

    assign cur_idx = idx_reg;

    `WPS_ASSERT_IMPL(a_idx_step, aclk, aresetn, $past(aresetn) && (idx_reg != $past(idx_reg)), idx_reg == $past(idx_reg) + IDX_W'(1))
    `WPS_ASSERT_IMPL(a_idx_leaves_wait, aclk, aresetn, $past(aresetn) && (idx_reg != $past(idx_reg)), $past(wait_reg) && !wait_reg)
    `WPS_ASSERT_IMPL(a_dwell_start, aclk, aresetn, $past(aresetn) && $rose(wait_reg), dwell_reg == $past(b_item.timestamp))

endmodule
